// File: src/sgi_pkg.sv
// Shared types and constants for the segment intersection pipeline.
// No dependencies.
package sgi_pkg;

	localparam int NUM_COORDS   = 10;
	localparam int PT_FRAC_BITS = 8;
	localparam int PT_WIDTH     = 24;

	typedef struct packed {
		logic valid;
		logic hit;
		logic eq;
	} sgi_flags_t;

endpackage

// File: src/sgi_setup.sv
// Front stages: differences, cross products, determinant sums and sign normalization.
// Depends on sgi_pkg.
module sgi_setup import sgi_pkg::*; #(
	parameter int CW  = 16,
	parameter int INW = 160,
	parameter int PW  = 2 * CW + 3,
	parameter int SW  = 6 * CW + 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [INW-1:0]       in_data,
	output sgi_flags_t           flags,
	output logic [PW-1:0]        num,
	output logic [PW-1:0]        den,
	output logic [SW-1:0]        side
);

	localparam int DW = CW + 1;
	localparam int PP = 2 * CW + 2;

	logic signed [CW-1:0] c [NUM_COORDS];
	for (genvar i = 0; i < NUM_COORDS; i++) begin : g_unpack
		assign c[i] = in_data[i*CW +: CW];
	end

	function automatic logic signed [DW-1:0] sub(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return DW'(a) - DW'(b);
	endfunction

	logic                  v_s1, v_s2, v_s3;
	logic signed [DW-1:0]  dax_s1, day_s1, daz_s1, dbx_s1, dby_s1, ebx_s1, eby_s1;
	logic signed [CW-1:0]  asx_s1, asy_s1, asz_s1;
	logic signed [PP-1:0]  p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic [SW-1:0]         side_s2, side_s3;
	logic signed [PW-1:0]  denb_s3, numb_s3, numa_s3;
	logic signed [PW-1:0]  nb_c, na_c, dm_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			flags <= '0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			flags.valid <= v_s3;
			flags.hit   <= (denb_s3 != '0) && !nb_c[PW-1] && (nb_c <= dm_c)
				&& !na_c[PW-1] && (na_c <= dm_c);
			flags.eq    <= (na_c == dm_c);
		end
	end

	always_comb begin
		dm_c = denb_s3[PW-1] ? -denb_s3 : denb_s3;
		nb_c = denb_s3[PW-1] ? numb_s3 : -numb_s3;
		na_c = (!denb_s3[PW-1] && denb_s3 != '0) ? numa_s3 : -numa_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dax_s1 <= sub(c[3], c[0]);
			day_s1 <= sub(c[4], c[1]);
			daz_s1 <= sub(c[5], c[2]);
			dbx_s1 <= sub(c[8], c[6]);
			dby_s1 <= sub(c[9], c[7]);
			ebx_s1 <= sub(c[6], c[0]);
			eby_s1 <= sub(c[7], c[1]);
			asx_s1 <= c[0];
			asy_s1 <= c[1];
			asz_s1 <= c[2];

			p0_s2   <= day_s1 * dbx_s1;
			p1_s2   <= dax_s1 * dby_s1;
			p2_s2   <= day_s1 * ebx_s1;
			p3_s2   <= dax_s1 * eby_s1;
			p4_s2   <= dbx_s1 * eby_s1;
			p5_s2   <= dby_s1 * ebx_s1;
			side_s2 <= {daz_s1, day_s1, dax_s1, asz_s1, asy_s1, asx_s1};

			denb_s3 <= PW'(p0_s2) - PW'(p1_s2);
			numb_s3 <= PW'(p2_s2) - PW'(p3_s2);
			numa_s3 <= PW'(p4_s2) - PW'(p5_s2);
			side_s3 <= side_s2;

			num  <= na_c;
			den  <= dm_c;
			side <= side_s3;
		end
	end

endmodule

// File: src/sgi_div.sv
// Restoring divider, one quotient bit per pipeline stage, for the parameter along A.
// Depends on sgi_pkg.
module sgi_div import sgi_pkg::*; #(
	parameter int PW = 35,
	parameter int T  = 16,
	parameter int SW = 99
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  sgi_flags_t    in_flags,
	input  logic [PW-1:0] in_num,
	input  logic [PW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output sgi_flags_t    out_flags,
	output logic [T:0]    out_t,
	output logic [SW-1:0] out_side
);

	sgi_flags_t     flags_s [1:T];
	logic [PW-1:0]  rem_s   [1:T];
	logic [PW-1:0]  den_s   [1:T];
	logic [T-1:0]   q_s     [1:T];
	logic [SW-1:0]  side_s  [1:T];

	sgi_flags_t     flags_in [T];
	logic [PW-1:0]  rem_in   [T];
	logic [PW-1:0]  den_in   [T];
	logic [T-1:0]   q_in     [T];
	logic [SW-1:0]  side_in  [T];

	for (genvar i = 0; i < T; i++) begin : g_stage
		if (i == 0) begin : g_first
			assign flags_in[i] = in_flags;
			assign rem_in[i]   = in_num;
			assign den_in[i]   = in_den;
			assign q_in[i]     = '0;
			assign side_in[i]  = in_side;
		end else begin : g_next
			assign flags_in[i] = flags_s[i];
			assign rem_in[i]   = rem_s[i];
			assign den_in[i]   = den_s[i];
			assign q_in[i]     = q_s[i];
			assign side_in[i]  = side_s[i];
		end

		logic [PW:0] rem2, diff;
		logic        ge;
		always_comb begin
			rem2 = {rem_in[i], 1'b0};
			diff = rem2 - {1'b0, den_in[i]};
			ge   = rem2 >= {1'b0, den_in[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				flags_s[i+1] <= '0;
			end else if (en) begin
				flags_s[i+1] <= flags_in[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[PW-1:0] : rem2[PW-1:0];
				den_s[i+1]  <= den_in[i];
				q_s[i+1]    <= {q_in[i][T-2:0], ge};
				side_s[i+1] <= side_in[i];
			end
		end
	end

	assign out_flags = flags_s[T];
	assign out_t     = flags_s[T].eq ? {1'b1, {T{1'b0}}} : {1'b0, q_s[T]};
	assign out_side  = side_s[T];

endmodule

// File: src/sgi_lerp.sv
// Crossing point: t times the A direction, rounded to Q.8, plus the A start point.
// Depends on sgi_pkg.
module sgi_lerp import sgi_pkg::*; #(
	parameter int CW  = 16,
	parameter int T   = 16,
	parameter int SW  = 99,
	parameter int OTW = 96
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  sgi_flags_t     in_flags,
	input  logic [T:0]     in_t,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic           out_hit,
	output logic [OTW-1:0] out_data
);

	localparam int DW  = CW + 1;
	localparam int MW  = CW + T + 3;
	localparam int LW  = (CW + T + 4 > PT_WIDTH + 1) ? CW + T + 4 : PT_WIDTH + 1;
	localparam int R   = T - PT_FRAC_BITS;
	localparam logic signed [LW-1:0] HALF = LW'((1 << R) >> 1);

	logic                 v_s1, hit_s1;
	logic [T:0]           t_s1;
	logic signed [MW-1:0] m_s1 [3];
	logic signed [CW-1:0] s_s1 [3];

	logic signed [CW-1:0] s_in [3];
	logic signed [DW-1:0] d_in [3];
	for (genvar k = 0; k < 3; k++) begin : g_axis_in
		assign s_in[k] = in_side[k*CW +: CW];
		assign d_in[k] = in_side[3*CW + k*DW +: DW];
	end

	logic [PT_WIDTH-1:0] pt [3];
	for (genvar k = 0; k < 3; k++) begin : g_axis_out
		logic signed [LW-1:0] pe, se, sum;
		always_comb begin
			pe  = LW'(m_s1[k]);
			se  = LW'(s_s1[k]) <<< PT_FRAC_BITS;
			sum = se + ((pe + HALF) >>> R);
			pt[k] = hit_s1 ? sum[PT_WIDTH-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_flags.valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1 <= in_flags.hit;
			t_s1   <= in_t;
			for (int k = 0; k < 3; k++) begin
				m_s1[k] <= MW'(d_in[k]) * MW'($signed({1'b0, in_t}));
				s_s1[k] <= s_in[k];
			end
			out_hit  <= hit_s1;
			out_data <= OTW'({pt[2], pt[1], pt[0], hit_s1 ? t_s1 : {(T+1){1'b0}}});
		end
	end

endmodule

// File: src/segment_intersection.sv
// Two-dimensional segment intersection: one segment pair per cycle, fully pipelined.
// Depends on sgi_pkg, sgi_setup, sgi_div and sgi_lerp.
//
// Accepts one segment pair per clock and returns one result word per pair, in order.
// The pipeline has four front stages for differences, cross products, sums and
// range test, one stage per quotient bit in the divider, and two for the
// interpolation multiply and rounding. The whole pipeline holds when the
// output word is not taken. A miss (parallel, collinear or out of range) returns
// hit = 0 with all fields zero.
module segment_intersection import sgi_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
	// b_start_x, b_start_y, b_end_x, b_end_y; zero padded
	input  logic [((NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// t_along_a, cross_x, cross_y, cross_z; zero padded
	output logic [((T_FRAC_BITS+1+3*PT_WIDTH+7)/8)*8-1:0] m_tdata,
	// hit
	output logic m_tuser
);

	localparam int INW = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
	localparam int OTW = ((T_FRAC_BITS + 1 + 3 * PT_WIDTH + 7) / 8) * 8;
	localparam int PW  = 2 * COORD_WIDTH + 3;
	localparam int SW  = 6 * COORD_WIDTH + 3;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	sgi_flags_t      setup_flags, div_flags;
	logic [PW-1:0]   setup_num, setup_den;
	logic [SW-1:0]   setup_side, div_side;
	logic [T_FRAC_BITS:0] div_t;

	sgi_setup #(.CW(COORD_WIDTH), .INW(INW), .PW(PW), .SW(SW)) u_setup (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid), .in_data(s_tdata),
		.flags(setup_flags), .num(setup_num), .den(setup_den), .side(setup_side)
	);

	sgi_div #(.PW(PW), .T(T_FRAC_BITS), .SW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_flags(setup_flags), .in_num(setup_num), .in_den(setup_den),
		.in_side(setup_side),
		.out_flags(div_flags), .out_t(div_t), .out_side(div_side)
	);

	sgi_lerp #(.CW(COORD_WIDTH), .T(T_FRAC_BITS), .SW(SW), .OTW(OTW)) u_lerp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_flags(div_flags), .in_t(div_t), .in_side(div_side),
		.out_valid(m_tvalid), .out_hit(m_tuser), .out_data(m_tdata)
	);

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss word carries nonzero fields");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[T_FRAC_BITS:0] <= {1'b1, {T_FRAC_BITS{1'b0}}})
		else $error("t_along_a above one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(div_t) && $stable(div_flags))
		else $error("pipeline moved during stall");
`endif

endmodule

// File: sim/tb_segment_intersection.sv
// Testbench for segment_intersection: random and directed segment pairs, scoreboard check.
// Depends on sgi_pkg and the segment_intersection RTL.
module tb_segment_intersection;
	import sgi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 16;
	localparam int TF = 16;
	localparam int DW = ((NUM_COORDS*CW+7)/8)*8;
	localparam int OW = ((TF+1+3*PT_WIDTH+7)/8)*8;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic hit;
		logic [TF:0] t_a;
		logic [PT_WIDTH-1:0] cx;
		logic [PT_WIDTH-1:0] cy;
		logic [PT_WIDTH-1:0] cz;
	} crossing_t;

	typedef logic signed [CW-1:0] coord_t;

	class crossing_board;
		crossing_t pending[$];
		int errors;

		static function automatic bit param_in_unit(longint num, longint den, output longint tq);
			longint n, d;
			n = -num;
			d = den;
			tq = 0;
			if (d == 0)
				return 0;
			if (d < 0) begin
				n = -n;
				d = -d;
			end
			if (n < 0 || n > d)
				return 0;
			if (n == d) begin
				tq = longint'(1) << TF;
				return 1;
			end
			for (int i = 0; i < TF; i++) begin
				n = n * 2;
				tq = tq << 1;
				if (n >= d) begin
					n = n - d;
					tq = tq | 1;
				end
			end
			return 1;
		endfunction

		static function automatic logic [PT_WIDTH-1:0] lerp(longint s, longint e, longint t);
			longint v, f;
			v = (e - s) * t;
			// floor((v + half) >> shift) via arithmetic shift
			f = (v + (longint'(1) << (TF - PT_FRAC_BITS - 1))) >>> (TF - PT_FRAC_BITS);
			return PT_WIDTH'(s * (longint'(1) << PT_FRAC_BITS) + f);
		endfunction

		function void note_pair(coord_t c[NUM_COORDS]);
			longint asx, asy, asz, aex, aey, aez, bsx, bsy, bex, bey;
			longint dax, day, dbx, dby, den_b, num_b, num_a, tb, ta;
			crossing_t r;
			asx = c[0]; asy = c[1]; asz = c[2]; aex = c[3]; aey = c[4]; aez = c[5];
			bsx = c[6]; bsy = c[7]; bex = c[8]; bey = c[9];
			dax = aex - asx; day = aey - asy; dbx = bex - bsx; dby = bey - bsy;
			den_b = day * dbx - dax * dby;
			num_b = day * (bsx - asx) - dax * (bsy - asy);
			num_a = dby * (asx - bsx) - dbx * (asy - bsy);
			r = '0;
			if (param_in_unit(num_b, den_b, tb) && param_in_unit(num_a, -den_b, ta)) begin
				r.hit = 1'b1;
				r.t_a = ta[TF:0];
				r.cx = lerp(asx, aex, ta);
				r.cy = lerp(asy, aey, ta);
				r.cz = lerp(asz, aez, ta);
			end
			pending.push_back(r);
		endfunction

		function void check_result(crossing_t got);
			crossing_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.hit !== exp.hit) begin
				$display("%0t: hit exp %b got %b", $time, exp.hit, got.hit);
				errors++;
			end
			if (got.t_a !== exp.t_a) begin
				$display("%0t: t_along_a exp %h got %h", $time, exp.t_a, got.t_a);
				errors++;
			end
			if (got.cx !== exp.cx) begin
				$display("%0t: cross_x exp %h got %h", $time, exp.cx, got.cx);
				errors++;
			end
			if (got.cy !== exp.cy) begin
				$display("%0t: cross_y exp %h got %h", $time, exp.cy, got.cy);
				errors++;
			end
			if (got.cz !== exp.cz) begin
				$display("%0t: cross_z exp %h got %h", $time, exp.cz, got.cz);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OW-1:0] m_tdata;
	logic m_tuser;

	crossing_board board = new();
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	bit hold_off = 1'b0;
	int cycles = 0;

	segment_intersection #(.COORD_WIDTH(CW), .T_FRAC_BITS(TF)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_segment_intersection NOT OK");
			$finish;
		end
	end

	// receiver
	always @(posedge clk) begin
		crossing_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.hit = m_tuser;
			got.t_a = m_tdata[TF:0];
			got.cx = m_tdata[TF+1 +: PT_WIDTH];
			got.cy = m_tdata[TF+1+PT_WIDTH +: PT_WIDTH];
			got.cz = m_tdata[TF+1+2*PT_WIDTH +: PT_WIDTH];
			board.check_result(got);
		end
		m_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic send_pair(coord_t c[NUM_COORDS]);
		logic [DW-1:0] w;
		w = '0;
		for (int i = 0; i < NUM_COORDS; i++)
			w[i*CW +: CW] = c[i];
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_pair(c);
	endtask

	task automatic send_random(int mode);
		coord_t c[NUM_COORDS];
		int span;
		for (int i = 0; i < NUM_COORDS; i++)
			c[i] = coord_t'($urandom);
		if (mode == 1) begin
			// crossing-prone pairs, small span in two of three draws, full span otherwise
			span = $urandom_range(1, 3) == 1 ? 32767 : 200;
			for (int i = 0; i < NUM_COORDS; i++)
				c[i] = coord_t'($urandom_range(2 * span) - span);
			// force B to straddle A's line often
			c[6] = c[0] + c[3] - c[0] / 2 - c[3] / 2 - coord_t'($urandom_range(50));
			c[8] = c[6] + coord_t'($urandom_range(100));
		end else if (mode == 2) begin
			// parallel copy of A
			c[6] = c[0] + 3; c[7] = c[1]; c[8] = c[3] + 3; c[9] = c[4];
		end
		send_pair(c);
	endtask

	initial begin
		coord_t c[NUM_COORDS];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: X crossing, endpoints touching, parallel, collinear, degenerate, extremes
		c = '{-100, -100, 7, 100, 100, -9, -100, 100, 100, -100}; send_pair(c);
		c = '{0, 0, 0, 10, 0, 10, 10, -5, 10, 5}; send_pair(c);
		c = '{0, 0, 0, 10, 0, 10, 0, -5, 0, 5}; send_pair(c);
		c = '{0, 0, 0, 10, 0, 0, 0, 1, 10, 1}; send_pair(c);
		c = '{0, 0, 0, 10, 0, 0, 2, 0, 20, 0}; send_pair(c);
		c = '{5, 5, 5, 5, 5, 5, 0, 0, 10, 10}; send_pair(c);
		c = '{0, 0, 0, 10, 0, 0, 11, -5, 11, 5}; send_pair(c);
		c = '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767, -32768};
		send_pair(c);
		c = '{32767, -32768, 32767, -32768, 32767, -32768, -32768, -32768, 32767, 32767};
		send_pair(c);
		c = '{0, 0, 0, 3, 0, 3, 1, -1, 2, 1}; send_pair(c);
		c = '{0, 0, -1, 7, 3, 1, 1, 3, 5, -2}; send_pair(c);
		c = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1}; send_pair(c);
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 19 : 69) : 0;
			snk_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 19 : 69) : 0;
			for (int n = 0; n < 225; n++)
				send_random($urandom_range(9) < 7 ? 1 : ($urandom_range(1) ? 0 : 2));
		end
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (TF + 20) @(posedge clk);
		if (board.errors == 0)
			$display("tb_segment_intersection OK");
		else
			$display("tb_segment_intersection NOT OK");
		$finish;
	end

	// long receiver hold-off while the sender keeps going
	initial begin
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_off = 1'b1;
		repeat (120) @(posedge clk);
		hold_off = 1'b0;
	end
endmodule
